FILE: rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants of the hierarchical bitmap pool
// Mode and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

   // default pool size, 2^12 slots
   localparam int LOG2_CAPACITY_DEF = 12;
   localparam int WORD_BITS         = 64;
   localparam int WORD_IDX_BITS     = 6;

   // request modes
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_TAKE   = 2'd2;

   // response status codes
   localparam logic [2:0] ST_PRESENT     = 3'd0;
   localparam logic [2:0] ST_ADD_EMPTY   = 3'd1;
   localparam logic [2:0] ST_ADD_NONEMP  = 3'd2;
   localparam logic [2:0] ST_ABSENT      = 3'd3;
   localparam logic [2:0] ST_REM_EMPTY   = 3'd4;
   localparam logic [2:0] ST_REM_NONEMP  = 3'd5;
   localparam logic [2:0] ST_EMPTY       = 3'd6;
   localparam logic [2:0] ST_TAKEN       = 3'd7;

   // sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MRD_DN,
      S_MPK,
      S_LRD,
      S_LEAF,
      S_MRD_UP,
      S_MUP
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/hbp_if.sv
// ----------------------------------------------------------------------------
// hbp_if: request and response channels of the bitmap pool
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] slot_index;
   logic [6:0]  pick_hint;

   modport source (output valid, output mode, output slot_index, output pick_hint,
                   input ready);
   modport sink   (input valid, input mode, input slot_index, input pick_hint,
                   output ready);
endinterface

interface hbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [11:0] taken_index;

   modport source (output valid, output status, output taken_index, input ready);
   modport sink   (input valid, input status, input taken_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/hierarchical_bitmap_pool_core.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_pool_core: slot pool held as leaf bitmaps with summaries
// Add, remove and take-any over 2^LOG2_CAPACITY slots.
// ----------------------------------------------------------------------------
// Usage
//  req carries mode, slot_index and pick_hint; rsp returns status and
//  taken_index, one response per request, in order.
//  One request is worked on at a time by a small sequencer around one
//  circular bit-search unit and the leaf and middle word memories.
//  States from request transfer to response valid:
//    take on an empty two- or three-level pool, or undefined mode: none
//    add / remove: S_LRD, S_LEAF, plus S_MRD_UP, S_MUP for a middle word
//    take: S_MRD_DN, S_MPK with three levels, then S_LRD, S_LEAF, then
//    S_MRD_UP, S_MUP when the pool has three levels and the leaf word empties
//  These steps follow from the registered reads of the word memories.
//  The next request can transfer in the cycle its predecessor's
//  response is presented, if the receiver takes it then; a new request is
//  not taken while one is still being worked on.
//  A finished response sits in an output register; the next request is
//  taken in the cycle that register drains, so a stalled receiver holds
//  off further requests but loses nothing.
//  After reset the word memories are cleared one entry per cycle, through
//  all 2^(LOG2_CAPACITY-6) leaf words; req.ready stays low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_bitmap_pool_core #(
   parameter int LOG2_CAPACITY = hbp_pkg::LOG2_CAPACITY_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   hbp_req_if.sink   req,
   hbp_rsp_if.source rsp
);
   import hbp_pkg::*;

   localparam int SW        = LOG2_CAPACITY;
   localparam int LEAF_BITS = LOG2_CAPACITY - 6;
   localparam int MID_BITS  = (LOG2_CAPACITY > 12) ? (LOG2_CAPACITY - 12) : 0;
   localparam int NLEAF     = 1 << LEAF_BITS;
   localparam int NMID      = 1 << MID_BITS;
   localparam int LEVELS    = (LOG2_CAPACITY > 12) ? 3 : ((LOG2_CAPACITY > 6) ? 2 : 1);
   localparam int LAW       = (LEAF_BITS > 0) ? LEAF_BITS : 1;
   localparam int MAW       = (MID_BITS > 0) ? MID_BITS : 1;
   localparam logic [LAW-1:0] LEAF_MASK = LAW'(NLEAF - 1);
   localparam logic [MAW-1:0] MID_MASK  = MAW'(NMID - 1);

   // circular search: rotate left, lowest or highest set bit, undo rotation
   function automatic logic [5:0] pick_bit(input logic [63:0] w, input logic [6:0] h);
      logic [63:0] rot;
      logic [5:0]  b;
      rot = (w << h[5:0]) | (w >> (7'd64 - {1'b0, h[5:0]}));
      if (h[6]) begin
         b = 6'd0;
         for (int i = 0; i < WORD_BITS; i++) begin
            if (rot[i]) b = 6'(i);
         end
      end else begin
         b = 6'd63;
         for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (rot[i]) b = 6'(i);
         end
      end
      return b - h[5:0];
   endfunction

   state_type state_ff, state_in;
   logic [1:0]     mode_ff, mode_in;
   logic [SW-1:0]  slot_ff, slot_in;
   logic [6:0]     hint_ff, hint_in;
   logic [LAW-1:0] leaf_addr_ff, leaf_addr_in;
   logic [MAW-1:0] mid_addr_ff, mid_addr_in;
   logic [63:0]    summary_ff, summary_in;
   logic [LAW-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     status_ff, status_in;
   logic [11:0]    taken_ff, taken_in;

   logic [63:0] leaf_mem [NLEAF];
   logic [63:0] mid_mem  [NMID];
   logic [63:0] leaf_rd_ff, mid_rd_ff;

   logic           leaf_we, mid_we;
   logic [LAW-1:0] leaf_wa;
   logic [MAW-1:0] mid_wa;
   logic [63:0]    leaf_wd, mid_wd;

   logic [63:0] pick_word;
   logic [6:0]  pick_hint_sel;
   logic [5:0]  pick_res;
   logic        accept;
   logic        out_free;

   // shared search unit input
   always_comb begin
      case (state_ff)
         S_IDLE:  pick_word = summary_ff;
         S_MPK:   pick_word = mid_rd_ff;
         default: pick_word = leaf_rd_ff;
      endcase
      pick_hint_sel = (state_ff == S_IDLE) ? req.pick_hint : hint_ff;
      pick_res      = pick_bit(pick_word, pick_hint_sel);
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.taken_index = taken_ff;

   // sequencer
   always_comb begin
      logic [63:0]    old_w, new_w, bit_m, sum_new;
      logic [5:0]     bsel, top;
      logic [LAW-1:0] leaf_i;
      logic           is_add, is_rem;

      state_in     = state_ff;
      mode_in      = mode_ff;
      slot_in      = slot_ff;
      hint_in      = hint_ff;
      leaf_addr_in = leaf_addr_ff;
      mid_addr_in  = mid_addr_ff;
      summary_in   = summary_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in    = status_ff;
      taken_in     = taken_ff;
      leaf_we      = 1'b0;
      leaf_wa      = leaf_addr_ff;
      leaf_wd      = '0;
      mid_we       = 1'b0;
      mid_wa       = mid_addr_ff;
      mid_wd       = '0;

      is_add = (mode_ff == MODE_ADD);
      is_rem = (mode_ff == MODE_REMOVE);
      old_w  = leaf_rd_ff;
      bsel   = (mode_ff == MODE_TAKE) ? pick_res : 6'(slot_ff);
      bit_m  = 64'd1 << bsel;
      new_w  = old_w & ~bit_m;
      leaf_i = leaf_addr_ff;
      top    = (LEVELS == 3) ? 6'(mid_addr_ff) : 6'(leaf_addr_ff);
      sum_new = summary_ff & ~(64'd1 << top);

      case (state_ff)
         // sweep both word memories to zero
         S_CLEAR: begin
            leaf_we = 1'b1;
            leaf_wa = clr_ff;
            if (clr_ff < LAW'(NMID)) begin
               mid_we = 1'b1;
               mid_wa = MAW'(clr_ff);
            end
            clr_in = clr_ff + LAW'(1);
            if (clr_ff == LEAF_MASK) state_in = S_IDLE;
         end

         // take a request, descend the summary for take-any
         S_IDLE: begin
            if (accept) begin
               mode_in      = req.mode;
               slot_in      = SW'(req.slot_index);
               hint_in      = req.pick_hint;
               leaf_addr_in = LAW'(SW'(req.slot_index) >> 6) & LEAF_MASK;
               case (req.mode)
                  MODE_ADD, MODE_REMOVE: state_in = S_LRD;
                  MODE_TAKE: begin
                     if (LEVELS == 1) begin
                        leaf_addr_in = '0;
                        state_in     = S_LRD;
                     end else if (summary_ff == 64'd0) begin
                        rsp_valid_in = 1'b1;
                        status_in    = ST_EMPTY;
                        taken_in     = '0;
                     end else if (LEVELS == 3) begin
                        mid_addr_in = MAW'(pick_res) & MID_MASK;
                        state_in    = S_MRD_DN;
                     end else begin
                        leaf_addr_in = LAW'(pick_res) & LEAF_MASK;
                        state_in     = S_LRD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_EMPTY;
                     taken_in     = '0;
                  end
               endcase
            end
         end

         S_MRD_DN: state_in = S_MPK;

         // middle word read back, pick the leaf
         S_MPK: begin
            leaf_addr_in = LAW'({mid_addr_ff, pick_res}) & LEAF_MASK;
            state_in     = S_LRD;
         end

         S_LRD: state_in = S_LEAF;

         // leaf word read back: test, set or clear the slot bit
         S_LEAF: begin
            state_in    = S_IDLE;
            taken_in    = '0;
            mid_addr_in = MAW'(leaf_i >> 6) & MID_MASK;
            if (!is_add && !is_rem) taken_in = 12'({leaf_i, pick_res});
            if (is_add) begin
               if ((old_w & bit_m) != 64'd0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_PRESENT;
               end else begin
                  leaf_we = 1'b1;
                  leaf_wd = old_w | bit_m;
                  if (old_w != 64'd0) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_ADD_NONEMP;
                  end else if (LEVELS == 1) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_ADD_EMPTY;
                  end else if (LEVELS == 3) begin
                     state_in = S_MRD_UP;
                  end else begin
                     summary_in   = summary_ff | (64'd1 << 6'(leaf_i));
                     rsp_valid_in = 1'b1;
                     status_in    = (summary_ff != 64'd0) ? ST_ADD_NONEMP : ST_ADD_EMPTY;
                  end
               end
            end else if (is_rem && ((old_w & bit_m) == 64'd0)) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_ABSENT;
            end else if (!is_rem && old_w == 64'd0) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_EMPTY;
               taken_in     = '0;
            end else begin
               leaf_we = 1'b1;
               leaf_wd = new_w;
               if (new_w != 64'd0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = is_rem ? ST_REM_NONEMP : ST_TAKEN;
               end else if (LEVELS == 1) begin
                  rsp_valid_in = 1'b1;
                  status_in    = is_rem ? ST_REM_EMPTY : ST_TAKEN;
               end else if (LEVELS == 3) begin
                  state_in = S_MRD_UP;
               end else begin
                  summary_in   = sum_new;
                  rsp_valid_in = 1'b1;
                  status_in    = !is_rem ? ST_TAKEN :
                                 ((sum_new == 64'd0) ? ST_REM_EMPTY : ST_REM_NONEMP);
               end
            end
         end

         S_MRD_UP: state_in = S_MUP;

         // middle word read back: update it and the summary
         S_MUP: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            mid_we       = 1'b1;
            if (is_add) begin
               mid_wd = mid_rd_ff | (64'd1 << 6'(leaf_i));
               if (mid_rd_ff != 64'd0) begin
                  status_in = ST_ADD_NONEMP;
               end else begin
                  summary_in = summary_ff | (64'd1 << top);
                  status_in  = (summary_ff != 64'd0) ? ST_ADD_NONEMP : ST_ADD_EMPTY;
               end
            end else begin
               mid_wd = mid_rd_ff & ~(64'd1 << 6'(leaf_i));
               if (mid_wd != 64'd0) begin
                  status_in = is_rem ? ST_REM_NONEMP : ST_TAKEN;
               end else begin
                  summary_in = sum_new;
                  status_in  = !is_rem ? ST_TAKEN :
                               ((sum_new == 64'd0) ? ST_REM_EMPTY : ST_REM_NONEMP);
               end
            end
         end

         default: state_in = S_CLEAR;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         summary_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      slot_ff      <= slot_in;
      hint_ff      <= hint_in;
      leaf_addr_ff <= leaf_addr_in;
      mid_addr_ff  <= mid_addr_in;
      status_ff    <= status_in;
      taken_ff     <= taken_in;
   end

   // leaf word memory
   always_ff @(posedge clock) begin
      if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
      leaf_rd_ff <= leaf_mem[leaf_addr_ff];
   end

   // middle word memory
   always_ff @(posedge clock) begin
      if (mid_we) mid_mem[mid_wa] <= mid_wd;
      mid_rd_ff <= mid_mem[mid_addr_ff];
   end

endmodule

`default_nettype wire
